[design/srvd_pkg.sv]
// Shared constants for the scaled RMS vector distance unit.
// No dependencies; imported by scaled_rms_vector_distance_unit.
package srvd_pkg;

    localparam int MAX_LEN_DEF = 4096;

    // Fixed field and datapath widths
    localparam int FEAT_W  = 16;             // signed Q7.8 feature
    localparam int MAG_W   = FEAT_W;         // |a - b| fits 16 bits unsigned
    localparam int SQ_W    = 2 * MAG_W;      // squared difference, Q16 units
    localparam int SCALE   = 1000;
    localparam int SCALE_W = 10;             // bits needed for SCALE
    localparam int Q_W     = SQ_W + SCALE_W; // mean square times SCALE
    localparam int ROOT_W  = (Q_W + 1) / 2;  // integer square root
    localparam int DIST_W  = 21;             // result field

endpackage

[design/scaled_rms_vector_distance_unit.sv]
// Scaled RMS distance between two fixed-point vectors streamed pair by pair.
// Depends on srvd_pkg for widths and constants.
//
// Usage:
//   Input channel s_*: one element pair per transaction (s_first_value,
//   s_second_value, signed Q7.8) plus s_last on the final pair of a vector.
//   Result channel m_*: one transaction per vector, m_distance =
//   floor(sqrt(1000 * sum of squared differences / element count)), Q.8.
//   Pairs beyond MAX_LEN are dropped from the sum and the count; their last
//   flag still closes the vector.
// Timing:
//   A pair without last passes through accept, square and accumulate steps;
//   s_ready is low during the last two. A pair with last adds a scaling step,
//   a restoring division over SUM_W + 10 dividend bits (54 at MAX_LEN = 4096)
//   and a square root of ROOT_W = 21 result bits, both on one shared
//   subtractor; m_valid rises when the square root finishes.
//   s_ready stays low through the square and accumulate steps of each pair
//   and through the scaling, division and root of each vector.
// Reset and stalls:
//   aresetn (synchronous, active low) clears the sum, the count, the
//   sequencer and m_valid. A pending result is held in m_distance while the
//   receiver stalls; new pairs are still accepted, but the next vector's
//   division waits until that result is taken.
module scaled_rms_vector_distance_unit
    import srvd_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [FEAT_W-1:0] s_first_value,
    input  logic signed [FEAT_W-1:0] s_second_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic        [DIST_W-1:0] m_distance
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SUM_W  = SQ_W + $clog2(MAX_LEN);
    localparam int DIV_W  = SUM_W + SCALE_W;
    localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCALE,
        ST_DIV,
        ST_SQRT
    } state_t;

    state_t             state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               take_reg, take_next;
    logic               last_reg, last_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   divisor_reg, divisor_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [Q_W-1:0]     rad_reg, rad_next;
    logic [SUB_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;

    logic signed [FEAT_W:0] diff_in;
    logic [FEAT_W:0]        diff_abs;
    logic [DIV_W-1:0]       scaled_sum;

    // Shared subtract/compare unit
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_res;
    logic             sub_ge;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_distance = dist_reg;

    assign diff_in  = (FEAT_W+1)'(s_first_value) - (FEAT_W+1)'(s_second_value);
    assign diff_abs = diff_in[FEAT_W] ? (FEAT_W+1)'(-diff_in) : (FEAT_W+1)'(diff_in);

    // 1000 * sum = 1024 * sum - 16 * sum - 8 * sum
    assign scaled_sum = (DIV_W'(sum_reg) << 10) - (DIV_W'(sum_reg) << 4)
                      - (DIV_W'(sum_reg) << 3);

    always_comb begin
        if (state_reg == ST_SQRT) begin
            sub_a = {rem_reg[SUB_W-3:0], rad_reg[Q_W-1 -: 2]};
            sub_b = SUB_W'({root_reg, 2'b01});
        end else begin
            sub_a = {rem_reg[SUB_W-2:0], div_reg[DIV_W-1]};
            sub_b = SUB_W'(divisor_reg);
        end
        sub_res = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge  = !sub_res[SUB_W];
    end

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        take_next    = take_reg;
        last_next    = last_reg;
        sq_next      = sq_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        divisor_next = divisor_reg;
        div_next     = div_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        dist_next    = dist_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = diff_abs[MAG_W-1:0];
                    take_next  = (cnt_reg < CNT_W'(MAX_LEN));
                    last_next  = s_last;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                sq_next    = SQ_W'(mag_reg * mag_reg);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (take_reg) begin
                    sum_next = sum_reg + SUM_W'(sq_reg);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = last_reg ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE: begin
                // Hold until the previous result has left the output register
                if (!m_valid_reg) begin
                    divisor_next = cnt_reg;
                    div_next     = (cnt_reg == '0) ? '0 : scaled_sum;
                    rem_next     = '0;
                    step_next    = STEP_W'(DIV_W - 1);
                    sum_next     = '0;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = sub_ge ? sub_res[SUB_W-1:0] : sub_a;
                div_next = {div_reg[DIV_W-2:0], sub_ge};
                if (step_reg == '0) begin
                    rad_next   = div_next[Q_W-1:0];
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_SQRT: begin
                rem_next  = sub_ge ? sub_res[SUB_W-1:0] : sub_a;
                rad_next  = {rad_reg[Q_W-3:0], 2'b00};
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                if (step_reg == '0) begin
                    dist_next    = DIST_W'(root_next);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg     <= mag_next;
        take_reg    <= take_next;
        last_reg    <= last_next;
        sq_reg      <= sq_next;
        divisor_reg <= divisor_next;
        div_reg     <= div_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        step_reg    <= step_next;
        dist_reg    <= dist_next;
    end

    // Element count saturates at MAX_LEN
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("element count above MAX_LEN");

    // A result only appears at the end of the square root
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_SQRT))
        else $error("result raised outside the root step");

    // The division never starts with a pending result or an empty vector
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE && state_next == ST_DIV) |=>
            (!m_valid_reg && divisor_reg != '0))
        else $error("division started with result pending or zero count");

endmodule

[tb/scaled_rms_vector_distance_unit_test.sv]
// Self-checking testbench for scaled_rms_vector_distance_unit: streams element pairs,
// predicts each vector's scaled RMS distance and checks every result transaction.
// Depends on srvd_pkg and the scaled_rms_vector_distance_unit RTL.
module scaled_rms_vector_distance_unit_test
    import srvd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [FEAT_W-1:0] s_first_value;
    logic signed [FEAT_W-1:0] s_second_value;
    logic                     s_last;
    logic                     m_valid;
    logic                     m_ready;
    logic        [DIST_W-1:0] m_distance;

    // Predictor state for the vector currently being accumulated
    logic [43:0]              square_sum;
    logic [12:0]              pair_count;
    logic [DIST_W-1:0]        pending_distances[$];
    logic [DIST_W-1:0]        oldest_distance;

    int error_count       = 0;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int recv_hold_cycles  = 0;

    scaled_rms_vector_distance_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_value  (s_first_value),
        .s_second_value (s_second_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance     (m_distance)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Floor of the square root by bitwise trial from the top bit down
    function automatic logic [DIST_W-1:0] floor_sqrt(input logic [63:0] value);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= value)
                root = trial;
        end
        return root[DIST_W-1:0];
    endfunction

    task automatic accumulate_pair(input logic signed [FEAT_W-1:0] first_val,
                                   input logic signed [FEAT_W-1:0] second_val,
                                   input logic is_last);
        int          diff;
        logic [15:0] mag;
        logic [63:0] mean_scaled;
        // Drop pairs once the vector has reached its maximum length
        if (pair_count < MAX_LEN_DEF) begin
            diff = int'(first_val) - int'(second_val);
            mag = 16'((diff < 0) ? -diff : diff);
            square_sum = square_sum + 44'(mag) * 44'(mag);
            pair_count = pair_count + 1'b1;
        end
        if (is_last) begin
            mean_scaled = '0;
            if (pair_count != 0)
                mean_scaled = (64'(SCALE) * 64'(square_sum)) / 64'(pair_count);
            pending_distances.push_back(floor_sqrt(mean_scaled));
            square_sum = '0;
            pair_count = '0;
        end
    endtask

    task automatic send_pair(input logic signed [FEAT_W-1:0] first_val,
                             input logic signed [FEAT_W-1:0] second_val,
                             input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_value  <= first_val;
        s_second_value <= second_val;
        s_last         <= is_last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        accumulate_pair(first_val, second_val, is_last);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge aclk);
        // Let the divider and root settle before changing the traffic pattern
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic signed [FEAT_W-1:0] random_feature();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3, 4, 5: return 16'(int'($urandom_range(511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_vector(input int len);
        for (int i = 1; i <= len; i++)
            send_pair(random_feature(), random_feature(), i == len);
    endtask

    task automatic test_directed_pairs();
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh0001, 16'sh0000, 1'b1);
        send_pair(16'shffff, 16'sh0000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh00ff, 16'shff00, 1'b1);
        send_pair(16'sh5555, 16'shaaaa, 1'b0);
        send_pair(16'shaaaa, 16'sh5555, 1'b0);
        send_pair(16'sh0000, 16'sh7fff, 1'b0);
        send_pair(16'sh8000, 16'sh0000, 1'b1);
        send_pair(16'sh0100, -16'sh0100, 1'b0);
        send_pair(16'sh0064, 16'sh0064, 1'b0);
        send_pair(-16'sh0005, 16'sh0007, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_vectors(input int item_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < item_budget) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 6);
            send_random_vector(len);
            sent += len;
        end
        wait_results_drained();
    endtask

    task automatic test_result_backpressure();
        // Hold the result channel long enough that pending vectors stall the input
        recv_hold_cycles = 600;
        for (int v = 0; v < 40; v++)
            send_random_vector($urandom_range(1, 3));
        wait_results_drained();
    endtask

    task automatic test_long_vector();
        // Full-scale differences over a long vector drive the quotient widest and the sum large
        for (int i = 1; i <= 256; i++)
            send_pair(16'sh8000, 16'sh7fff, i == 256);
        send_random_vector(48);
        wait_results_drained();
    endtask

    // Result channel: random stalls, or a counted hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (recv_hold_cycles > 0) begin
                m_ready <= 1'b0;
                recv_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                $display("%0t: unexpected result transaction: expected none, actual %0d",
                         $time, m_distance);
                error_count++;
            end else begin
                oldest_distance = pending_distances.pop_front();
                if (m_distance !== oldest_distance) begin
                    $display("%0t: distance mismatch: expected %0d, actual %0d",
                             $time, oldest_distance, m_distance);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_first_value  = '0;
        s_second_value = '0;
        s_last         = 1'b0;
        square_sum     = '0;
        pair_count     = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_pairs();

        send_idle_pct = 27;
        recv_idle_pct = 45;
        test_random_vectors(300);

        send_idle_pct = 45;
        recv_idle_pct = 27;
        test_random_vectors(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_vectors(300);

        recv_idle_pct = 20;
        test_result_backpressure();

        recv_idle_pct = 0;
        test_long_vector();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/srvd_pkg.sv
design/scaled_rms_vector_distance_unit.sv
tb/scaled_rms_vector_distance_unit_test.sv
